FILE: rtl/cmtp_pkg.sv
// Shared widths, status codes and defaults for the CAN message text parser.
`default_nettype none

package cmtp_pkg;

   localparam int unsigned CH_W       = 8;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned ID_W       = 11;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned ACC_W      = 32;
   localparam int unsigned OUT_BYTES  = 8;
   localparam int unsigned MAX_BYTES_DEF = 8;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ID   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_BYTE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ID    = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/cmtp_if.sv
// Valid/ready channel interfaces for command characters and parsed messages.
`default_nettype none

interface cmtp_req_if;
   import cmtp_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface cmtp_rsp_if;
   import cmtp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     msg_id;
   logic [COUNT_W-1:0]  byte_count;
   logic [BYTE_W-1:0]   byte0;
   logic [BYTE_W-1:0]   byte1;
   logic [BYTE_W-1:0]   byte2;
   logic [BYTE_W-1:0]   byte3;
   logic [BYTE_W-1:0]   byte4;
   logic [BYTE_W-1:0]   byte5;
   logic [BYTE_W-1:0]   byte6;
   logic [BYTE_W-1:0]   byte7;

   modport source (output valid, output status, output msg_id, output byte_count,
                   output byte0, output byte1, output byte2, output byte3,
                   output byte4, output byte5, output byte6, output byte7,
                   input ready);
   modport sink   (input valid, input status, input msg_id, input byte_count,
                   input byte0, input byte1, input byte2, input byte3,
                   input byte4, input byte5, input byte6, input byte7,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/can_message_text_parser_core.sv
// Streaming parser from command text to CAN identifier, length and data bytes.
// A terminator passes from the character register to the result register.
// Throughput: one character per cycle; the character register stalls only when it
// holds a terminator while the result register is full and not being taken.
// Reset (synchronous, active high): clears the parse state, the data byte store,
// the character register valid flag and the result register valid flag.
`default_nettype none

module can_message_text_parser_core #(
   parameter int unsigned MAX_BYTES = cmtp_pkg::MAX_BYTES_DEF
) (
   input  wire          clock,
   input  wire          reset,
   cmtp_req_if.sink     req,
   cmtp_rsp_if.source   rsp
);
   import cmtp_pkg::*;

   // Index into the data byte store; at least one bit even for a single entry.
   localparam int unsigned IdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   // Parse position, one-hot.
   typedef enum logic [3:0] {
      PH_BETWEEN  = 4'b0001,
      PH_LEADZERO = 4'b0010,
      PH_NUMBER   = 4'b0100,
      PH_STOPPED  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_BIN = 2'd2
   } radix_type;

   localparam logic [CH_W-1:0] CH_TERM  = 8'h00;
   localparam logic [CH_W-1:0] CH_SEP_HI = 8'h20;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UA    = 8'h41;
   localparam logic [CH_W-1:0] CH_UB    = 8'h42;
   localparam logic [CH_W-1:0] CH_UF    = 8'h46;
   localparam logic [CH_W-1:0] CH_UX    = 8'h58;
   localparam logic [CH_W-1:0] CH_LA    = 8'h61;
   localparam logic [CH_W-1:0] CH_LB    = 8'h62;
   localparam logic [CH_W-1:0] CH_LF    = 8'h66;
   localparam logic [CH_W-1:0] CH_LX    = 8'h78;

   // ---------------------------------------------------------------------
   // Character register: one transaction deep, drains whenever the parse
   // step can retire it.
   // ---------------------------------------------------------------------
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] ch_ff;
   logic            is_term;
   logic            advance;

   // Parse state.
   phase_type          phase_ff, phase_in;
   radix_type          radix_ff, radix_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               have_id_ff, have_id_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [STATUS_W-1:0] err_ff, err_in;
   logic [BYTE_W-1:0]  bytes_ff [MAX_BYTES];
   logic [BYTE_W-1:0]  bytes_in [MAX_BYTES];

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [BYTE_W-1:0]   rsp_bytes_ff [OUT_BYTES];
   logic [BYTE_W-1:0]   rsp_bytes_in [OUT_BYTES];

   // Character classes.
   logic             is_sep, is_dec, is_bin, is_hex_lo, is_hex_up, digit_ok;
   logic [3:0]       dval;
   logic [ACC_W-1:0] acc_step;

   // Parse step control.
   logic             take_en, take_fail, post_take, start_dec;
   logic [ACC_W-1:0] take_val;

   assign is_term = (ch_ff == CH_TERM);
   // Only a terminator needs room in the result register.
   assign advance = in_valid_ff && (!is_term || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req.valid && req.ready) begin
         ch_ff <= req.ch;
      end
   end

   // ---------------------------------------------------------------------
   // Character decode and digit accumulation.
   // ---------------------------------------------------------------------
   always_comb begin
      is_sep    = (ch_ff != CH_TERM) && (ch_ff <= CH_SEP_HI);
      is_dec    = (ch_ff >= CH_ZERO) && (ch_ff <= CH_NINE);
      is_bin    = (ch_ff == CH_ZERO) || (ch_ff == CH_ONE);
      is_hex_lo = (ch_ff >= CH_LA) && (ch_ff <= CH_LF);
      is_hex_up = (ch_ff >= CH_UA) && (ch_ff <= CH_UF);
      // Letters a..f and A..F share their low nibble: 1..6 maps to 10..15.
      dval      = is_dec ? ch_ff[3:0] : (ch_ff[3:0] + 4'd9);
      case (radix_ff)
         RX_BIN:  digit_ok = is_bin;
         RX_HEX:  digit_ok = is_dec || is_hex_lo || is_hex_up;
         default: digit_ok = is_dec;
      endcase
      case (radix_ff)
         RX_HEX:  acc_step = {acc_ff[ACC_W-5:0], dval};
         RX_BIN:  acc_step = {acc_ff[ACC_W-2:0], dval[0]};
         // Times ten as two shifts and an add, wrapping at 32 bits.
         default: acc_step = (acc_ff << 3) + (acc_ff << 1) + {28'd0, dval};
      endcase
   end

   // ---------------------------------------------------------------------
   // One parse step per retired character.
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in   = phase_ff;
      radix_in   = radix_ff;
      acc_in     = acc_ff;
      have_id_in = have_id_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      err_in     = err_ff;
      bytes_in   = bytes_ff;
      take_en    = 1'b0;
      take_val   = acc_ff;
      take_fail  = 1'b0;
      post_take  = 1'b0;
      start_dec  = 1'b0;

      if (is_term) begin
         // Flush an open number into the message.
         take_en = (phase_ff == PH_LEADZERO) || (phase_ff == PH_NUMBER);
      end else begin
         unique case (phase_ff)
            PH_BETWEEN: begin
               if (!is_sep) begin
                  if (is_dec) begin
                     start_dec = 1'b1;
                  end else begin
                     phase_in = PH_STOPPED;
                  end
               end
            end
            PH_LEADZERO: begin
               if ((ch_ff == CH_LX) || (ch_ff == CH_UX)) begin
                  radix_in = RX_HEX;
                  acc_in   = '0;
                  phase_in = PH_NUMBER;
               end else if ((ch_ff == CH_LB) || (ch_ff == CH_UB)) begin
                  radix_in = RX_BIN;
                  acc_in   = '0;
                  phase_in = PH_NUMBER;
               end else if (is_dec) begin
                  acc_in   = {28'd0, dval};
                  phase_in = PH_NUMBER;
               end else begin
                  // A lone zero ends here.
                  take_en   = 1'b1;
                  take_val  = '0;
                  post_take = 1'b1;
               end
            end
            PH_NUMBER: begin
               if (digit_ok) begin
                  acc_in = acc_step;
               end else begin
                  take_en   = 1'b1;
                  post_take = 1'b1;
               end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
         endcase
      end

      // Hand the finished number to the message.
      if (take_en) begin
         phase_in = PH_BETWEEN;
         if (!have_id_ff) begin
            if (|take_val[ACC_W-1:ID_W]) begin
               take_fail = 1'b1;
               err_in    = ST_BAD_ID;
            end else begin
               id_in      = take_val[ID_W-1:0];
               have_id_in = 1'b1;
            end
         end else if (count_ff >= COUNT_W'(MAX_BYTES)) begin
            take_fail = 1'b1;
            err_in    = ST_TOO_MANY;
         end else if (|take_val[ACC_W-1:BYTE_W]) begin
            take_fail = 1'b1;
            err_in    = ST_BAD_BYTE;
         end else begin
            bytes_in[count_ff[IdxW-1:0]] = take_val[BYTE_W-1:0];
            count_in = count_ff + 4'd1;
         end
         if (take_fail) begin
            phase_in = PH_STOPPED;
         end
      end

      // The character that ended a token opens the next position.
      if (post_take && !take_fail && !is_sep) begin
         if ((phase_ff == PH_NUMBER) && (radix_ff == RX_BIN) && is_dec) begin
            start_dec = 1'b1;
         end else begin
            phase_in = PH_STOPPED;
         end
      end

      if (start_dec) begin
         radix_in = RX_DEC;
         acc_in   = {28'd0, dval};
         phase_in = (ch_ff == CH_ZERO) ? PH_LEADZERO : PH_NUMBER;
      end

      // Result fields come from the message after the final flush.
      if (err_in != ST_OK) begin
         rsp_status_in = err_in;
      end else begin
         rsp_status_in = have_id_in ? ST_OK : ST_NO_ID;
      end
      rsp_id_in    = have_id_in ? id_in : '0;
      rsp_count_in = count_in;

      // Start the next message; the byte store carries over.
      if (is_term) begin
         phase_in   = PH_BETWEEN;
         radix_in   = RX_DEC;
         acc_in     = '0;
         have_id_in = 1'b0;
         count_in   = '0;
         id_in      = '0;
         err_in     = ST_OK;
      end
   end

   // Entries beyond the store read as zero.
   for (genvar g = 0; g < OUT_BYTES; g++) begin : g_out_bytes
      if (g < MAX_BYTES) begin : g_used
         assign rsp_bytes_in[g] = bytes_in[g];
      end else begin : g_unused
         assign rsp_bytes_in[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         radix_ff   <= RX_DEC;
         acc_ff     <= '0;
         have_id_ff <= 1'b0;
         count_ff   <= '0;
         id_ff      <= '0;
         err_ff     <= ST_OK;
         for (int i = 0; i < MAX_BYTES; i++) begin
            bytes_ff[i] <= '0;
         end
      end else if (advance) begin
         phase_ff   <= phase_in;
         radix_ff   <= radix_in;
         acc_ff     <= acc_in;
         have_id_ff <= have_id_in;
         count_ff   <= count_in;
         id_ff      <= id_in;
         err_ff     <= err_in;
         bytes_ff   <= bytes_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on a retired terminator, drop when taken.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && is_term) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && is_term) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_bytes_ff  <= rsp_bytes_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.msg_id     = rsp_id_ff;
   assign rsp.byte_count = rsp_count_ff;
   assign rsp.byte0      = rsp_bytes_ff[0];
   assign rsp.byte1      = rsp_bytes_ff[1];
   assign rsp.byte2      = rsp_bytes_ff[2];
   assign rsp.byte3      = rsp_bytes_ff[3];
   assign rsp.byte4      = rsp_bytes_ff[4];
   assign rsp.byte5      = rsp_bytes_ff[5];
   assign rsp.byte6      = rsp_bytes_ff[6];
   assign rsp.byte7      = rsp_bytes_ff[7];

endmodule

`default_nettype wire

FILE: rtl/cmtp_checker.sv
// Port-level assertions for the CAN message text parser, bound to the parser core.
`default_nettype none

module cmtp_assertions (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire [cmtp_pkg::CH_W-1:0]       req_ch,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [cmtp_pkg::STATUS_W-1:0]   rsp_status,
   input wire [cmtp_pkg::ID_W-1:0]       rsp_msg_id,
   input wire [cmtp_pkg::COUNT_W-1:0]    rsp_byte_count
);
   import cmtp_pkg::*;

   // A fresh result must trace back to an earlier terminator transaction.
   a_rsp_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_ch == '0), 2))
      else $error("result without a terminator two cycles earlier");

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                && $stable(rsp_msg_id) && $stable(rsp_byte_count))
      else $error("stalled result changed");

   // Without an identifier no data bytes are taken.
   a_no_id_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ST_BAD_ID) || (rsp_status == ST_NO_ID))
      |-> (rsp_msg_id == '0) && (rsp_byte_count == '0))
      else $error("identifier error with id or data bytes");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind can_message_text_parser_core cmtp_assertions u_cmtp_assertions (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_ch         (req.ch),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_msg_id     (rsp.msg_id),
   .rsp_byte_count (rsp.byte_count)
);

`default_nettype wire

FILE: dv/cmtp_checker.sv
// Channel monitor and message predictor for the CAN message text parser.

module cmtp_checker #(
   parameter int unsigned MAX_BYTES = cmtp_pkg::MAX_BYTES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   cmtp_req_if         req_mon,
   cmtp_rsp_if         rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned checked
);
   import cmtp_pkg::*;

   typedef enum logic [3:0] {
      SCAN_GAP       = 4'b0001,
      SCAN_LEAD_ZERO = 4'b0010,
      SCAN_DIGITS    = 4'b0100,
      SCAN_HALTED    = 4'b1000
   } scan_phase_type;

   typedef enum logic [1:0] {
      RDX_DEC,
      RDX_HEX,
      RDX_BIN
   } radix_type;

   typedef struct packed {
      logic [STATUS_W-1:0]                status;
      logic [ID_W-1:0]                    msg_id;
      logic [COUNT_W-1:0]                 byte_count;
      logic [OUT_BYTES-1:0][BYTE_W-1:0]   data;
   } can_frame_type;

   localparam logic [ACC_W-1:0] ID_LIMIT   = 32'h7ff;
   localparam logic [ACC_W-1:0] BYTE_LIMIT = 32'hff;
   localparam logic [CH_W-1:0]  TERMINATOR = 8'd0;
   localparam logic [CH_W-1:0]  SEP_FIRST  = 8'd1;
   localparam logic [CH_W-1:0]  SEP_LAST   = 8'd32;

   scan_phase_type      scan_phase;
   radix_type           radix;
   logic [ACC_W-1:0]    acc;
   logic                id_seen;
   logic [COUNT_W-1:0]  n_bytes;
   logic [ID_W-1:0]     id_val;
   logic [BYTE_W-1:0]   byte_store [OUT_BYTES];
   logic [STATUS_W-1:0] err_code;

   can_frame_type pending_frames [$];
   int unsigned   err_total = 0;
   int unsigned   frame_total = 0;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
   end

   function automatic bit is_sep(input logic [CH_W-1:0] c);
      return c >= SEP_FIRST && c <= SEP_LAST;
   endfunction

   function automatic bit is_dec(input logic [CH_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int digit_value(input logic [CH_W-1:0] c, input radix_type r);
      if (r == RDX_BIN) return (c == "0" || c == "1") ? int'(c - "0") : -1;
      if (is_dec(c)) return int'(c - "0");
      if (r == RDX_HEX) begin
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      end
      return -1;
   endfunction

   task automatic clear_message();
      scan_phase = SCAN_GAP;
      radix      = RDX_DEC;
      acc        = '0;
      id_seen    = 1'b0;
      n_bytes    = '0;
      id_val     = '0;
      err_code   = ST_OK;
   endtask

   task automatic halt(input logic [STATUS_W-1:0] code);
      err_code   = code;
      scan_phase = SCAN_HALTED;
   endtask

   // The first number is the identifier, later ones are data bytes.
   task automatic commit_number(input logic [ACC_W-1:0] n);
      scan_phase = SCAN_GAP;
      if (!id_seen) begin
         if (n > ID_LIMIT) begin
            halt(ST_BAD_ID);
         end else begin
            id_val  = n[ID_W-1:0];
            id_seen = 1'b1;
         end
      end else if (n_bytes >= MAX_BYTES) begin
         halt(ST_TOO_MANY);
      end else if (n > BYTE_LIMIT) begin
         halt(ST_BAD_BYTE);
      end else begin
         byte_store[n_bytes[2:0]] = n[BYTE_W-1:0];
         n_bytes = n_bytes + 1'b1;
      end
   endtask

   task automatic start_decimal(input logic [CH_W-1:0] c);
      radix      = RDX_DEC;
      acc        = ACC_W'(c - "0");
      scan_phase = (c == "0") ? SCAN_LEAD_ZERO : SCAN_DIGITS;
   endtask

   task automatic parse_char(input logic [CH_W-1:0] c);
      int            d;
      radix_type     was;
      can_frame_type f;
      if (c == TERMINATOR) begin
         if (scan_phase == SCAN_LEAD_ZERO || scan_phase == SCAN_DIGITS) commit_number(acc);
         f.status     = (err_code != ST_OK) ? err_code : (id_seen ? ST_OK : ST_NO_ID);
         f.msg_id     = id_seen ? id_val : '0;
         f.byte_count = n_bytes;
         for (int i = 0; i < OUT_BYTES; i++) f.data[i] = byte_store[i];
         pending_frames.push_back(f);
         clear_message();
      end else begin
         case (scan_phase)
            SCAN_GAP: begin
               if (!is_sep(c)) begin
                  if (is_dec(c)) start_decimal(c);
                  else scan_phase = SCAN_HALTED;
               end
            end
            SCAN_LEAD_ZERO: begin
               if (c == "x" || c == "X") begin
                  radix = RDX_HEX; acc = '0; scan_phase = SCAN_DIGITS;
               end else if (c == "b" || c == "B") begin
                  radix = RDX_BIN; acc = '0; scan_phase = SCAN_DIGITS;
               end else if (is_dec(c)) begin
                  acc = ACC_W'(c - "0"); scan_phase = SCAN_DIGITS;
               end else begin
                  commit_number('0);
                  if (scan_phase == SCAN_GAP && !is_sep(c)) scan_phase = SCAN_HALTED;
               end
            end
            SCAN_DIGITS: begin
               d = digit_value(c, radix);
               if (d >= 0) begin
                  case (radix)
                     RDX_HEX: acc = (acc << 4) + ACC_W'(d);
                     RDX_BIN: acc = (acc << 1) | ACC_W'(d);
                     default: acc = acc * 32'd10 + ACC_W'(d);
                  endcase
               end else begin
                  was = radix;
                  commit_number(acc);
                  // a digit that ends a binary token opens a decimal one
                  if (scan_phase == SCAN_GAP && !is_sep(c)) begin
                     if (was == RDX_BIN && is_dec(c)) start_decimal(c);
                     else scan_phase = SCAN_HALTED;
                  end
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      can_frame_type                    want;
      logic [OUT_BYTES-1:0][BYTE_W-1:0] got_data;
      if (reset) begin
         clear_message();
         for (int i = 0; i < OUT_BYTES; i++) byte_store[i] = '0;
         pending_frames.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) parse_char(req_mon.ch);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_data = {rsp_mon.byte7, rsp_mon.byte6, rsp_mon.byte5, rsp_mon.byte4,
                        rsp_mon.byte3, rsp_mon.byte2, rsp_mon.byte1, rsp_mon.byte0};
            if (pending_frames.size() == 0) begin
               $error("result with no message pending: status %0d msg_id %0d",
                      rsp_mon.status, rsp_mon.msg_id);
               err_total++;
            end else begin
               want = pending_frames.pop_front();
               frame_total++;
               if (rsp_mon.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_mon.status);
                  err_total++;
               end
               if (rsp_mon.msg_id !== want.msg_id) begin
                  $error("msg_id expected %0d actual %0d", want.msg_id, rsp_mon.msg_id);
                  err_total++;
               end
               if (rsp_mon.byte_count !== want.byte_count) begin
                  $error("byte_count expected %0d actual %0d",
                         want.byte_count, rsp_mon.byte_count);
                  err_total++;
               end
               for (int i = 0; i < OUT_BYTES; i++) begin
                  if (got_data[i] !== want.data[i]) begin
                     $error("byte%0d expected %0d actual %0d", i, want.data[i], got_data[i]);
                     err_total++;
                  end
               end
            end
         end
      end
      mismatches  <= err_total;
      outstanding <= pending_frames.size();
      checked     <= frame_total;
   end

endmodule

FILE: dv/tb_top.sv
// Top of the CAN message text parser testbench: clock, reset, stimulus and verdict.

module tb_top;
   import cmtp_pkg::*;

   // Length of the forced receiver stall that backs up the block.
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // Cycles with no transaction on either channel before the run is declared hung.
   localparam int unsigned STALL_LIMIT     = 5000;
   // Characters sent under each idle mix.
   localparam int unsigned PHASE_CHARS     = 340;
   // Cycles to wait before the verdict once no result is outstanding.
   localparam int unsigned TAIL_CYCLES     = 8;
   localparam logic [CH_W-1:0] TERMINATOR  = 8'd0;
   localparam logic [CH_W-1:0] SEP_LAST    = 8'd32;

   logic clock = 1'b0;
   logic reset;

   cmtp_req_if req_ch ();
   cmtp_rsp_if rsp_ch ();

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          hold_off_req   = 1'b0;
   int unsigned chars_sent     = 0;
   int unsigned msgs_sent      = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned checked;

   // Characters of the command being built, terminator included.
   logic [CH_W-1:0] text_q [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   can_message_text_parser_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   cmtp_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // Receiver: stall at random per the current mix; on request, hold off for a long
   // stretch so that the result register fills and the block stalls its input.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: restart the count on every transaction, give up when it runs out.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one character and hold it until the block takes it. Idle cycles go in
   // before the offer, so valid never drops and rises in the same time step.
   task automatic send_char(input logic [CH_W-1:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.ch    <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      chars_sent++;
      if (c == TERMINATOR) msgs_sent++;
   endtask

   // Send a literal command followed by its terminator.
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      send_char(TERMINATOR);
   endtask

   task automatic add_decimal(input logic [31:0] v, input int unsigned pad);
      logic [CH_W-1:0] digits [$];
      repeat (pad) text_q.push_back("0");
      do begin
         digits.push_front(8'("0") + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digits[i]) text_q.push_back(digits[i]);
   endtask

   // Hex with a random-case prefix and digits; a bare prefix stands for zero.
   task automatic add_hex(input logic [31:0] v, input bit bare);
      logic [CH_W-1:0] digits [$];
      logic [3:0]      nib;
      text_q.push_back("0");
      text_q.push_back($urandom_range(0, 1) ? "x" : "X");
      if (!bare) begin
         do begin
            nib = v[3:0];
            if (nib < 10) digits.push_front(8'("0") + 8'(nib));
            else digits.push_front(($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nib - 10));
            v = v >> 4;
         end while (v != 0);
      end
      foreach (digits[i]) text_q.push_back(digits[i]);
   endtask

   task automatic add_binary(input logic [31:0] v, input bit bare);
      logic [CH_W-1:0] digits [$];
      text_q.push_back("0");
      text_q.push_back($urandom_range(0, 1) ? "b" : "B");
      if (!bare) begin
         do begin
            digits.push_front(8'("0") + 8'(v[0]));
            v = v >> 1;
         end while (v != 0);
      end
      foreach (digits[i]) text_q.push_back(digits[i]);
   endtask

   // Write one number in a random notation; a few are long enough to wrap 32 bits.
   task automatic add_number(input logic [31:0] v);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) add_decimal(v, 0);
      else if (pick < 55) add_decimal(v, $urandom_range(1, 2));
      else if (pick < 75) add_hex(v, 1'b0);
      else if (pick < 90) add_binary(v, 1'b0);
      else if (pick < 93) add_hex(v, 1'b1);
      else if (pick < 96) add_binary(v, 1'b1);
      else repeat ($urandom_range(10, 14)) text_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
   endtask

   // Mostly spaces, sometimes any control byte; now and then nothing, gluing tokens.
   task automatic add_separator();
      if ($urandom_range(0, 99) < 5) return;
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 99) < 70) text_q.push_back(" ");
         else text_q.push_back(8'($urandom_range(1, SEP_LAST)));
      end
   endtask

   function automatic logic [31:0] random_id();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) return 32'h7ff;
      if (pick < 12) return 32'd0;
      if (pick < 18) return 32'd2048 + $urandom_range(0, 100000);
      return $urandom_range(0, 2047);
   endfunction

   function automatic logic [31:0] random_byte();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return 32'd255;
      if (pick < 16) return 32'd0;
      if (pick < 21) return 32'd256 + $urandom_range(0, 5000);
      return $urandom_range(0, 255);
   endfunction

   // Build one command: mostly well-formed with random content, the rest noise,
   // commands with no identifier, and commands broken by a stray character.
   task automatic build_command();
      int unsigned pick;
      int unsigned n_data;
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
         repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 10) begin
         if ($urandom_range(0, 1)) add_separator();
      end else begin
         if ($urandom_range(0, 3) == 0) add_separator();
         add_number(random_id());
         n_data = ($urandom_range(0, 99) < 8) ? $urandom_range(9, 10) : $urandom_range(0, 8);
         repeat (n_data) begin
            add_separator();
            add_number(random_byte());
         end
         if ($urandom_range(0, 3) == 0) add_separator();
         if ($urandom_range(0, 99) < 8) begin
            text_q.push_back(8'($urandom_range(SEP_LAST + 1, 255)));
            add_decimal($urandom_range(0, 99), 0);
         end
      end
      text_q.push_back(TERMINATOR);
   endtask

   task automatic run_commands(input int unsigned budget);
      int unsigned start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         build_command();
         foreach (text_q[i]) send_char(text_q[i]);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.ch    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: largest id in hex with the largest byte, bare binary prefix,
      // prefix after a second zero, binary token cut by a decimal digit, empty command.
      send_text("0x7ff 255");
      send_text("0b");
      send_text("00x5");
      send_text("0b12");
      send_text("");

      // Free run: no idling on either side.
      run_commands(PHASE_CHARS);

      // Back-pressure: keep offering short commands while the receiver holds off.
      hold_off_req = 1'b1;
      while (hold_off_req) send_text("7");

      // Sender idles, receiver always ready.
      send_idle_pct = 63;
      run_commands(PHASE_CHARS);

      // Receiver stalls, sender never idles.
      send_idle_pct  = 0;
      recv_stall_pct = 63;
      run_commands(PHASE_CHARS);

      // Both sides idle.
      send_idle_pct  = 34;
      recv_stall_pct = 34;
      run_commands(PHASE_CHARS);

      req_ch.valid <= 1'b0;

      // Drain: step once so the checker has seen the last terminator, then wait.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d commands across four idle mixes and a long stall;",
               chars_sent, msgs_sent);
      $display("compared %0d parsed messages, %0d field mismatches.", checked, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
